// ===== design/arpq_pkg.sv =====
// shared types and codes for the unsorted-array priority queue
package arpq_pkg;

  // operation codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // capacity register at reset
  localparam logic [4:0] CAP_RESET = 5'd16;

  // input item
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic        [1:0]  status;
    logic        [4:0]  occupancy;
  } out_item_t;

  // one stored entry
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       ins_write;
    logic       set_result;
    logic [1:0] res_status;
    logic       scan_start;
    logic       issue;
    logic       shift_start;
    logic       finish_remove;
    logic       out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic room;
    logic empty;
    logic idx_last;
    logic idx_end;
  } dp_stat_t;

endpackage

// ===== design/arpq_datapath.sv =====
// entry memory, count, scan and shift pipeline, result and output registers
module arpq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  arpq_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  input  arpq_pkg::dp_cmd_t   cmd,
  output arpq_pkg::dp_stat_t  stat,
  output arpq_pkg::out_item_t out_item
);
  import arpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  entry_t             mem [DEPTH];
  logic [CW-1:0]      count;
  logic [4:0]         capacity;
  logic [CW-1:0]      idx;
  logic               move_mode;
  logic               rd_vld;
  logic [AW-1:0]      rd_tag;
  entry_t             rd_data;
  logic [AW-1:0]      best_idx;
  entry_t             best;
  logic signed [31:0] res_value;
  logic signed [31:0] res_priority;
  logic [1:0]         res_status;

  logic [XW-1:0]      count_x;
  logic [XW-1:0]      cap_x;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;

  assign count_x = XW'(count);
  assign cap_x   = XW'(capacity);

  // controller status
  assign stat.room     = (count_x < cap_x) && (count != CW'(DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.idx_last = (idx == count - CW'(1));
  assign stat.idx_end  = (idx == count);

  // memory write source: insert at the tail or move an entry down one place
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = '{value: in_item.item_value, prio: in_item.item_priority};
    if (cmd.ins_write) begin
      wr_en = 1'b1;
    end else if (rd_vld && move_mode) begin
      wr_en   = 1'b1;
      wr_addr = rd_tag - AW'(1);
      wr_data = rd_data;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx[AW-1:0]];
    rd_tag  <= idx[AW-1:0];
  end

  // control registers: count, capacity, read tracking, scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= CAP_RESET;
      rd_vld    <= 1'b0;
      idx       <= '0;
      move_mode <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.ins_write) begin
        count <= count + CW'(1);
      end else if (cmd.finish_remove) begin
        count <= count - CW'(1);
      end
      rd_vld <= cmd.issue;
      if (cmd.scan_start) begin
        idx       <= '0;
        move_mode <= 1'b0;
      end else if (cmd.shift_start) begin
        idx       <= CW'(best_idx) + CW'(1);
        move_mode <= 1'b1;
      end else if (cmd.issue) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // running minimum, earliest entry kept on ties
  always_ff @(posedge clk) begin
    if (rd_vld && !move_mode) begin
      if (rd_tag == '0 || rd_data.prio < best.prio) begin
        best     <= rd_data;
        best_idx <= rd_tag;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.finish_remove) begin
      res_value    <= best.value;
      res_priority <= best.prio;
      res_status   <= ST_DONE;
    end else if (cmd.set_result) begin
      res_value    <= '0;
      res_priority <= '0;
      res_status   <= cmd.res_status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.out_value    <= res_value;
      out_item.out_priority <= res_priority;
      out_item.status       <= res_status;
      out_item.occupancy    <= count_x[4:0];
    end
  end

endmodule

// ===== design/arpq_ctrl.sv =====
// controller state machine for insert, scan, shift and result transfer
module arpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  arpq_pkg::dp_stat_t stat,
  output arpq_pkg::dp_cmd_t  cmd
);
  import arpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_SETUP,
    S_SHIFT,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_REMOVE) begin
            if (stat.empty) begin
              cmd.set_result = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end else begin
            cmd.set_result = 1'b1;
            if (stat.room) begin
              cmd.ins_write  = 1'b1;
              cmd.res_status = ST_DONE;
            end else begin
              cmd.res_status = ST_FULL;
            end
            state_next = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.idx_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.shift_start = 1'b1;
        state_next      = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.idx_end) begin
          state_next = S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          if (stat.idx_last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        cmd.finish_remove = 1'b1;
        state_next        = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/array_priority_queue_min_extract.sv =====
// Priority queue kept as an unsorted array of DEPTH entries in one memory with a
// single write port and a registered read port. An insert, or any refused item,
// sets the pending result, which then moves to the output register. In a remove,
// the memory read port visits every held entry once to find the smallest
// priority (earliest wins on ties), then once more for each later entry that
// moves down one place. One item is worked at a time; a new item is taken as
// soon as the previous result sits in the output register.
// The capacity register (reset 16) may be written only while the block is idle.
module array_priority_queue_min_extract #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  arpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output arpq_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);
  import arpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  arpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_item.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic
  arpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule
